// ===== hdl/jsv_pkg.sv =====
package jsv_pkg;

  localparam int MaxDepth = 1024;
  localparam int DepthW = $clog2(MaxDepth);
  localparam int CountW = DepthW + 1;
  localparam int QueueDepth = 2;

  localparam logic [2:0] ErrNone  = 3'd0;
  localparam logic [2:0] ErrByte  = 3'd1;
  localparam logic [2:0] ErrEsc   = 3'd2;
  localparam logic [2:0] ErrSurr  = 3'd3;
  localparam logic [2:0] ErrDeep  = 3'd4;
  localparam logic [2:0] ErrTrunc = 3'd5;
  localparam logic [2:0] ErrTop   = 3'd6;

  localparam logic [1:0] RegDepthLimit = 2'd0;
  localparam logic [1:0] RegTopObject  = 2'd1;

  typedef enum logic [24:0] {
    PH_TOP       = 25'd1 << 0,
    PH_VALUE     = 25'd1 << 1,
    PH_ARR_FIRST = 25'd1 << 2,
    PH_OBJ_FIRST = 25'd1 << 3,
    PH_OBJ_KEY   = 25'd1 << 4,
    PH_COLON     = 25'd1 << 5,
    PH_AFTER     = 25'd1 << 6,
    PH_DONE      = 25'd1 << 7,
    PH_STR       = 25'd1 << 8,
    PH_ESC       = 25'd1 << 9,
    PH_HEX       = 25'd1 << 10,
    PH_SURR_BS   = 25'd1 << 11,
    PH_SURR_U    = 25'd1 << 12,
    PH_N_MINUS   = 25'd1 << 13,
    PH_N_ZERO    = 25'd1 << 14,
    PH_N_INT     = 25'd1 << 15,
    PH_N_DOT     = 25'd1 << 16,
    PH_N_FRAC    = 25'd1 << 17,
    PH_N_EXP     = 25'd1 << 18,
    PH_N_EXPSIGN = 25'd1 << 19,
    PH_N_EXPDIG  = 25'd1 << 20,
    PH_L_TRUE    = 25'd1 << 21,
    PH_L_FALSE   = 25'd1 << 22,
    PH_L_NULL    = 25'd1 << 23,
    PH_ERR       = 25'd1 << 24
  } phase_t;

  // byte classes worked out by the front end
  typedef struct packed {
    logic       blank;
    logic       digit;
    logic       digit19;
    logic       hex_ok;
    logic [3:0] nibble;
    logic       simple_esc;
  } byte_class_t;

  typedef struct packed {
    logic [7:0]  data;
    logic        last;
    byte_class_t cls;
  } queue_item_t;

  function automatic logic [7:0] word_char(input logic [1:0] word, input logic [2:0] pos);
    logic [7:0] ch;
    ch = 8'h00;
    case (word)
      2'd0: case (pos)
        3'd1: ch = "r";
        3'd2: ch = "u";
        3'd3: ch = "e";
        default: ch = 8'h00;
      endcase
      2'd1: case (pos)
        3'd1: ch = "a";
        3'd2: ch = "l";
        3'd3: ch = "s";
        3'd4: ch = "e";
        default: ch = 8'h00;
      endcase
      default: case (pos)
        3'd1: ch = "u";
        3'd2: ch = "l";
        3'd3: ch = "l";
        default: ch = 8'h00;
      endcase
    endcase
    return ch;
  endfunction

endpackage

// ===== hdl/jsv_if.sv =====
interface jsv_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;
  modport source (output valid, data_byte, last_byte, input ready);
  modport sink (input valid, data_byte, last_byte, output ready);
endinterface

interface jsv_out_if;
  logic        valid;
  logic        ready;
  logic        valid_res;
  logic [2:0]  error_code;
  logic [31:0] error_offset;
  modport source (output valid, valid_res, error_code, error_offset, input ready);
  modport sink (input valid, valid_res, error_code, error_offset, output ready);
endinterface

// ===== hdl/json_syntax_validator_top.sv =====
// Byte-serial JSON syntax checker. One document byte is taken per cycle
// (data_byte, last_byte) unless stalled, and one result comes out for each byte
// marked last_byte: valid_res, the first error's code and its byte offset
// (saturating at 0xFFFFFFFF, zero when valid). A two-entry queue after the input
// byte classifier decouples the input from the grammar engine, and a result
// register holds the verdict, so throughput is one byte per cycle unless the
// output stalls. The container stack is a 1024 x 1 memory, one push or pop per
// byte. Registers at 0x0 depth_limit (reset 1024) and 0x4 top_must_be_object
// (reset 1) must be written only while idle; the block does not enforce it.
module json_syntax_validator_top (
  input  logic        clk,
  input  logic        rst,
  jsv_in_if.sink      in_ch,
  jsv_out_if.source   out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [10:0] depth_limit;
  logic        top_must_be_object;
  logic        q_valid;
  logic        q_pop;
  jsv_pkg::queue_item_t q_item;

  jsv_cfg u_cfg (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .depth_limit, .top_must_be_object
  );

  jsv_front u_front (
    .clk, .rst, .in_ch, .q_valid, .q_item, .q_pop
  );

  jsv_back u_back (
    .clk, .rst, .depth_limit, .top_must_be_object, .q_valid, .q_item, .q_pop, .out_ch
  );

endmodule

// ===== hdl/jsv_front.sv =====
module jsv_front (
  input  logic                 clk,
  input  logic                 rst,
  jsv_in_if.sink               in_ch,
  output logic                 q_valid,
  output jsv_pkg::queue_item_t q_item,
  input  logic                 q_pop
);

  localparam int PtrW = $clog2(jsv_pkg::QueueDepth);

  jsv_pkg::queue_item_t mem [jsv_pkg::QueueDepth];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [PtrW:0]   fill;
  logic            push;
  jsv_pkg::byte_class_t cls;
  logic [7:0] c;

  always_comb begin
    c = in_ch.data_byte;
    cls.blank = (c == " ") || (c == 8'h09) || (c == 8'h0d) || (c == 8'h0a);
    cls.digit = (c >= "0") && (c <= "9");
    cls.digit19 = (c >= "1") && (c <= "9");
    cls.hex_ok = 1'b1;
    cls.nibble = 4'd0;
    if (cls.digit) begin
      cls.nibble = 4'(c - "0");
    end else if ((c >= "a") && (c <= "f")) begin
      cls.nibble = 4'(c - "a" + 8'd10);
    end else if ((c >= "A") && (c <= "F")) begin
      cls.nibble = 4'(c - "A" + 8'd10);
    end else begin
      cls.hex_ok = 1'b0;
    end
    cls.simple_esc = (c == "\"") || (c == "\\") || (c == "/") || (c == "b") ||
                     (c == "f") || (c == "n") || (c == "r") || (c == "t");
  end

  assign in_ch.ready = (fill != (PtrW+1)'(jsv_pkg::QueueDepth));
  assign push = in_ch.valid && in_ch.ready;
  assign q_valid = (fill != '0);
  assign q_item = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= '{data: c, last: in_ch.last_byte, cls: cls};
    end
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (q_pop) rd_ptr <= rd_ptr + 1'b1;
      fill <= fill + (PtrW+1)'(push) - (PtrW+1)'(q_pop);
    end
  end

endmodule

// ===== hdl/jsv_back.sv =====
module jsv_back (
  input  logic                 clk,
  input  logic                 rst,
  input  logic [10:0]          depth_limit,
  input  logic                 top_must_be_object,
  input  logic                 q_valid,
  input  jsv_pkg::queue_item_t q_item,
  output logic                 q_pop,
  jsv_out_if.source            out_ch
);

  localparam int DW = jsv_pkg::DepthW;
  localparam int CW = jsv_pkg::CountW;

  logic stack_mem [jsv_pkg::MaxDepth];

  jsv_pkg::phase_t phase, phase_next;
  logic [CW-1:0] open_depth, open_depth_next;
  logic [15:0]   hex_acc, hex_acc_next;
  logic [2:0]    hex_seen, hex_seen_next;
  logic [2:0]    lit_pos, lit_pos_next;
  logic          surr_pend, surr_pend_next;
  logic          key_flag, key_flag_next;
  logic [31:0]   byte_cnt;
  logic [2:0]    first_err, first_err_next;
  logic [31:0]   first_off, first_off_next;
  // cached top-of-stack kind, kept in step with pushes and pops
  logic          top_obj, top_obj_next;
  logic          top_reload;
  logic          reload_pend;
  logic          top_obj_eff;

  logic          push_en;
  logic          push_val;
  logic [DW-1:0] rd_addr;
  logic          rd_data;

  logic          out_full;
  logic          step;
  logic [7:0]    c;
  jsv_pkg::byte_class_t k;
  logic [CW-1:0] lim;
  logic [15:0]   cp;
  logic [2:0]    res_code;

  assign c = q_item.data;
  assign k = q_item.cls;
  assign q_pop = q_valid && (!out_full || out_ch.ready);
  assign step = q_pop;
  assign lim = (depth_limit > 11'(jsv_pkg::MaxDepth)) ? CW'(jsv_pkg::MaxDepth)
                                                       : CW'(depth_limit);
  assign cp = {hex_acc[11:0], k.nibble};
  assign top_obj_eff = reload_pend ? rd_data : top_obj;

  logic          fail;
  logic [2:0]    fail_code;
  logic          done_req;
  logic          open_req;
  logic          open_obj;
  logic          close_req;
  logic          start_req;
  logic          refeed;
  jsv_pkg::phase_t ph2;

  // start of a value from byte c
  function automatic jsv_pkg::phase_t start_phase(input logic [7:0] ch,
                                                  input logic d19);
    jsv_pkg::phase_t p;
    p = jsv_pkg::PH_ERR;
    if (ch == "\"") p = jsv_pkg::PH_STR;
    else if (ch == "t") p = jsv_pkg::PH_L_TRUE;
    else if (ch == "f") p = jsv_pkg::PH_L_FALSE;
    else if (ch == "n") p = jsv_pkg::PH_L_NULL;
    else if (ch == "-") p = jsv_pkg::PH_N_MINUS;
    else if (ch == "0") p = jsv_pkg::PH_N_ZERO;
    else if (d19) p = jsv_pkg::PH_N_INT;
    return p;
  endfunction

  always_comb begin
    phase_next = phase;
    open_depth_next = open_depth;
    hex_acc_next = hex_acc;
    hex_seen_next = hex_seen;
    lit_pos_next = lit_pos;
    surr_pend_next = surr_pend;
    key_flag_next = key_flag;
    fail = 1'b0;
    fail_code = jsv_pkg::ErrByte;
    done_req = 1'b0;
    open_req = 1'b0;
    open_obj = 1'b0;
    close_req = 1'b0;
    start_req = 1'b0;
    refeed = 1'b0;
    ph2 = phase;

    unique case (phase)
      jsv_pkg::PH_TOP: begin
        if (!k.blank) begin
          if (top_must_be_object && c != "{") begin
            fail = 1'b1;
            fail_code = jsv_pkg::ErrTop;
          end else begin
            start_req = 1'b1;
          end
        end
      end
      jsv_pkg::PH_VALUE: if (!k.blank) start_req = 1'b1;
      jsv_pkg::PH_ARR_FIRST: begin
        if (!k.blank) begin
          if (c == "]") close_req = 1'b1;
          else start_req = 1'b1;
        end
      end
      jsv_pkg::PH_OBJ_FIRST, jsv_pkg::PH_OBJ_KEY: begin
        if (!k.blank) begin
          if (c == "}" && phase == jsv_pkg::PH_OBJ_FIRST) close_req = 1'b1;
          else if (c == "\"") begin
            key_flag_next = 1'b1;
            phase_next = jsv_pkg::PH_STR;
          end else fail = 1'b1;
        end
      end
      jsv_pkg::PH_COLON: begin
        if (!k.blank) begin
          if (c == ":") phase_next = jsv_pkg::PH_VALUE;
          else fail = 1'b1;
        end
      end
      jsv_pkg::PH_AFTER: begin
        if (!k.blank) begin
          if (c == ",") phase_next = top_obj_eff ? jsv_pkg::PH_OBJ_KEY : jsv_pkg::PH_VALUE;
          else if (c == "}" && top_obj_eff) close_req = 1'b1;
          else if (c == "]" && !top_obj_eff) close_req = 1'b1;
          else fail = 1'b1;
        end
      end
      jsv_pkg::PH_DONE: if (!k.blank) fail = 1'b1;
      jsv_pkg::PH_STR: begin
        if (c == "\\") phase_next = jsv_pkg::PH_ESC;
        else if (c == "\"") begin
          if (key_flag) begin
            key_flag_next = 1'b0;
            phase_next = jsv_pkg::PH_COLON;
          end else done_req = 1'b1;
        end
      end
      jsv_pkg::PH_ESC: begin
        if (c == "u") begin
          hex_acc_next = '0;
          hex_seen_next = '0;
          phase_next = jsv_pkg::PH_HEX;
        end else if (k.simple_esc) phase_next = jsv_pkg::PH_STR;
        else begin
          fail = 1'b1;
          fail_code = jsv_pkg::ErrEsc;
        end
      end
      jsv_pkg::PH_HEX: begin
        if (!k.hex_ok) begin
          fail = 1'b1;
          fail_code = jsv_pkg::ErrEsc;
        end else if (hex_seen != 3'd3) begin
          hex_acc_next = cp;
          hex_seen_next = hex_seen + 3'd1;
        end else begin
          hex_acc_next = '0;
          hex_seen_next = '0;
          if (surr_pend) begin
            surr_pend_next = 1'b0;
            if (cp < 16'hDC00 || cp > 16'hDFFF) begin
              fail = 1'b1;
              fail_code = jsv_pkg::ErrSurr;
            end else phase_next = jsv_pkg::PH_STR;
          end else if (cp >= 16'hD800 && cp <= 16'hDBFF) begin
            surr_pend_next = 1'b1;
            phase_next = jsv_pkg::PH_SURR_BS;
          end else if (cp >= 16'hDC00 && cp <= 16'hDFFF) begin
            fail = 1'b1;
            fail_code = jsv_pkg::ErrSurr;
          end else phase_next = jsv_pkg::PH_STR;
        end
      end
      jsv_pkg::PH_SURR_BS: begin
        if (c == "\\") phase_next = jsv_pkg::PH_SURR_U;
        else begin
          fail = 1'b1;
          fail_code = jsv_pkg::ErrSurr;
        end
      end
      jsv_pkg::PH_SURR_U: begin
        if (c == "u") begin
          hex_acc_next = '0;
          hex_seen_next = '0;
          phase_next = jsv_pkg::PH_HEX;
        end else begin
          fail = 1'b1;
          fail_code = jsv_pkg::ErrSurr;
        end
      end
      jsv_pkg::PH_N_MINUS: begin
        if (c == "0") phase_next = jsv_pkg::PH_N_ZERO;
        else if (k.digit19) phase_next = jsv_pkg::PH_N_INT;
        else fail = 1'b1;
      end
      jsv_pkg::PH_N_ZERO, jsv_pkg::PH_N_INT: begin
        if (phase == jsv_pkg::PH_N_INT && k.digit) phase_next = phase;
        else if (c == ".") phase_next = jsv_pkg::PH_N_DOT;
        else if (c == "e" || c == "E") phase_next = jsv_pkg::PH_N_EXP;
        else refeed = 1'b1;
      end
      jsv_pkg::PH_N_DOT: begin
        if (k.digit) phase_next = jsv_pkg::PH_N_FRAC;
        else fail = 1'b1;
      end
      jsv_pkg::PH_N_FRAC: begin
        if (k.digit) phase_next = phase;
        else if (c == "e" || c == "E") phase_next = jsv_pkg::PH_N_EXP;
        else refeed = 1'b1;
      end
      jsv_pkg::PH_N_EXP: begin
        if (c == "+" || c == "-") phase_next = jsv_pkg::PH_N_EXPSIGN;
        else if (k.digit) phase_next = jsv_pkg::PH_N_EXPDIG;
        else fail = 1'b1;
      end
      jsv_pkg::PH_N_EXPSIGN: begin
        if (k.digit) phase_next = jsv_pkg::PH_N_EXPDIG;
        else fail = 1'b1;
      end
      jsv_pkg::PH_N_EXPDIG: if (!k.digit) refeed = 1'b1;
      jsv_pkg::PH_L_TRUE, jsv_pkg::PH_L_FALSE, jsv_pkg::PH_L_NULL: begin
        logic [1:0] w;
        logic [2:0] len;
        w = (phase == jsv_pkg::PH_L_TRUE) ? 2'd0 :
            (phase == jsv_pkg::PH_L_FALSE) ? 2'd1 : 2'd2;
        len = (phase == jsv_pkg::PH_L_FALSE) ? 3'd5 : 3'd4;
        if (lit_pos >= len || c != jsv_pkg::word_char(w, lit_pos)) fail = 1'b1;
        else if (lit_pos + 3'd1 == len) begin
          lit_pos_next = '0;
          done_req = 1'b1;
        end else lit_pos_next = lit_pos + 3'd1;
      end
      jsv_pkg::PH_ERR: phase_next = jsv_pkg::PH_ERR;
      default: phase_next = jsv_pkg::PH_ERR;
    endcase

    // a finished number hands the byte on to the enclosing context
    if (refeed) begin
      ph2 = (open_depth == '0) ? jsv_pkg::PH_DONE : jsv_pkg::PH_AFTER;
      phase_next = ph2;
      if (!k.blank) begin
        if (ph2 == jsv_pkg::PH_DONE) fail = 1'b1;
        else if (c == ",") phase_next = top_obj_eff ? jsv_pkg::PH_OBJ_KEY : jsv_pkg::PH_VALUE;
        else if (c == "}" && top_obj_eff) close_req = 1'b1;
        else if (c == "]" && !top_obj_eff) close_req = 1'b1;
        else fail = 1'b1;
      end
    end

    if (start_req) begin
      if (c == "{" || c == "[") begin
        open_req = 1'b1;
        open_obj = (c == "{");
      end else begin
        phase_next = start_phase(c, k.digit19);
        if (phase_next == jsv_pkg::PH_STR) key_flag_next = 1'b0;
        if (c == "t" || c == "f" || c == "n") lit_pos_next = 3'd1;
        if (phase_next == jsv_pkg::PH_ERR) fail = 1'b1;
      end
    end

    push_en = 1'b0;
    push_val = open_obj;
    if (open_req) begin
      if (open_depth >= lim) begin
        fail = 1'b1;
        fail_code = jsv_pkg::ErrDeep;
      end else begin
        push_en = 1'b1;
        open_depth_next = open_depth + 1'b1;
        phase_next = open_obj ? jsv_pkg::PH_OBJ_FIRST : jsv_pkg::PH_ARR_FIRST;
      end
    end

    if (close_req) begin
      if (open_depth != '0) open_depth_next = open_depth - 1'b1;
      done_req = 1'b1;
    end

    if (done_req) begin
      phase_next = (open_depth_next == '0) ? jsv_pkg::PH_DONE : jsv_pkg::PH_AFTER;
    end

    first_err_next = first_err;
    first_off_next = first_off;
    if (fail) begin
      phase_next = jsv_pkg::PH_ERR;
      if (first_err == jsv_pkg::ErrNone) begin
        first_err_next = fail_code;
        first_off_next = byte_cnt;
      end
    end
  end

  // after a pop the new top comes from memory in the next cycle
  assign rd_addr = DW'(open_depth_next - CW'(1));
  assign top_reload = step && close_req && (open_depth_next != '0);

  always_comb begin
    top_obj_next = top_obj_eff;
    if (push_en) top_obj_next = push_val;
  end

  always_ff @(posedge clk) begin
    if (step && push_en) stack_mem[DW'(open_depth)] <= push_val;
    rd_data <= stack_mem[rd_addr];
  end

  // end-of-document verdict
  logic [31:0] cnt_inc;
  assign cnt_inc = (byte_cnt == 32'hFFFF_FFFF) ? byte_cnt : byte_cnt + 32'd1;

  always_comb begin
    res_code = first_err_next;
    if (first_err_next == jsv_pkg::ErrNone) begin
      unique case (phase_next)
        jsv_pkg::PH_DONE: res_code = jsv_pkg::ErrNone;
        jsv_pkg::PH_N_ZERO, jsv_pkg::PH_N_INT, jsv_pkg::PH_N_FRAC, jsv_pkg::PH_N_EXPDIG:
          res_code = (open_depth_next != '0) ? jsv_pkg::ErrTrunc : jsv_pkg::ErrNone;
        jsv_pkg::PH_TOP:
          res_code = top_must_be_object ? jsv_pkg::ErrTop : jsv_pkg::ErrTrunc;
        default: res_code = jsv_pkg::ErrTrunc;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (step && q_item.last) begin
      out_ch.valid_res <= (res_code == jsv_pkg::ErrNone);
      out_ch.error_code <= res_code;
      out_ch.error_offset <= (res_code == jsv_pkg::ErrNone) ? 32'd0 :
                             (first_err_next != jsv_pkg::ErrNone) ? first_off_next : cnt_inc;
    end
    if (rst) begin
      out_full <= 1'b0;
      phase <= jsv_pkg::PH_TOP;
      open_depth <= '0;
      hex_acc <= '0;
      hex_seen <= '0;
      lit_pos <= '0;
      surr_pend <= 1'b0;
      key_flag <= 1'b0;
      byte_cnt <= '0;
      first_err <= jsv_pkg::ErrNone;
      first_off <= '0;
      top_obj <= 1'b0;
      reload_pend <= 1'b0;
    end else begin
      if (step && q_item.last) out_full <= 1'b1;
      else if (out_ch.ready) out_full <= 1'b0;
      if (step && !q_item.last) top_obj <= top_obj_next;
      else if (reload_pend) top_obj <= rd_data;
      reload_pend <= step && !q_item.last && top_reload;
      if (step) begin
        if (q_item.last) begin
          phase <= jsv_pkg::PH_TOP;
          open_depth <= '0;
          hex_acc <= '0;
          hex_seen <= '0;
          lit_pos <= '0;
          surr_pend <= 1'b0;
          key_flag <= 1'b0;
          byte_cnt <= '0;
          first_err <= jsv_pkg::ErrNone;
          first_off <= '0;
        end else begin
          phase <= phase_next;
          open_depth <= open_depth_next;
          hex_acc <= hex_acc_next;
          hex_seen <= hex_seen_next;
          lit_pos <= lit_pos_next;
          surr_pend <= surr_pend_next;
          key_flag <= key_flag_next;
          byte_cnt <= cnt_inc;
          first_err <= first_err_next;
          first_off <= first_off_next;
        end
      end
    end
  end

  assign out_ch.valid = out_full;

endmodule

// ===== hdl/jsv_cfg.sv =====
module jsv_cfg (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output logic [10:0] depth_limit,
  output logic        top_must_be_object
);

  logic [1:0] reg_idx;
  assign reg_idx = {1'b0, paddr[2]};
  assign pready = 1'b1;

  always_comb begin
    prdata = '0;
    if (paddr[1:0] == 2'b00) begin
      unique case (reg_idx)
        jsv_pkg::RegDepthLimit: prdata = {21'd0, depth_limit};
        jsv_pkg::RegTopObject:  prdata = {31'd0, top_must_be_object};
        default: prdata = '0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      depth_limit <= 11'(jsv_pkg::MaxDepth);
      top_must_be_object <= 1'b1;
    end else if (psel && penable && pwrite) begin
      if (reg_idx == jsv_pkg::RegDepthLimit) depth_limit <= pwdata[10:0];
      if (reg_idx == jsv_pkg::RegTopObject) top_must_be_object <= pwdata[0];
    end
  end

endmodule

// ===== hdl/jsv_checker.sv =====
module jsv_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic        valid_res,
  input logic [2:0]  error_code,
  input logic [31:0] error_offset
);

  a_verdict: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (valid_res == (error_code == jsv_pkg::ErrNone)))
    else $error("verdict disagrees with error code");

  a_zero_off: assert property (@(posedge clk) disable iff (rst)
    (out_valid && valid_res) |-> (error_offset == 32'd0))
    else $error("valid document carries an offset");

  a_code_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (error_code <= jsv_pkg::ErrTop))
    else $error("error code out of range");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(error_code)))
    else $error("stalled result changed");

  a_ready_rst: assert property (@(posedge clk)
    $past(rst) |-> (!out_valid))
    else $error("result shown after reset");

endmodule

bind json_syntax_validator_top jsv_checker u_chk (
  .clk(clk), .rst(rst),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .valid_res(out_ch.valid_res), .error_code(out_ch.error_code),
  .error_offset(out_ch.error_offset)
);

// ===== tb/sv/tb_json_syntax_validator_top.sv =====
module tb_json_syntax_validator_top;

  localparam int CycleLimit = 400000;

  typedef struct {
    logic [7:0] data;
    logic       last;
  } doc_byte_t;

  typedef struct {
    logic        ok;
    logic [2:0]  code;
    logic [31:0] offset;
  } verdict_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic        psel, penable, pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  jsv_in_if  in_if ();
  jsv_out_if out_if ();

  json_syntax_validator_top dut (
    .clk     (clk),
    .rst     (rst),
    .in_ch   (in_if),
    .out_ch  (out_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  doc_byte_t pending_bytes[$];
  verdict_t  expected_verdicts[$];
  int        mismatches = 0;
  int        cycles = 0;

  // ---------------------------------------------------------------- grammar tracker
  logic [10:0] lim_reg;
  logic        top_obj_reg;

  jsv_pkg::phase_t gram_phase;
  bit          nest_is_obj [jsv_pkg::MaxDepth];
  int          nest_depth;
  logic [15:0] hex_acc;
  int          hex_cnt;
  int          word_pos;
  bit          surr_pending;
  logic [31:0] byte_pos;
  logic [2:0]  err_code;
  logic [31:0] err_pos;
  bit          in_key;

  function automatic void doc_reset();
    gram_phase   = jsv_pkg::PH_TOP;
    nest_depth   = 0;
    hex_acc      = '0;
    hex_cnt      = 0;
    word_pos     = 0;
    surr_pending = 0;
    byte_pos     = '0;
    err_code     = jsv_pkg::ErrNone;
    err_pos      = '0;
    in_key       = 0;
  endfunction

  function automatic void flag_error(logic [2:0] code);
    if (err_code == jsv_pkg::ErrNone) begin
      err_code = code;
      err_pos  = byte_pos;
    end
    gram_phase = jsv_pkg::PH_ERR;
  endfunction

  function automatic bit is_ws(logic [7:0] c);
    return c == 8'h20 || c == 8'h09 || c == 8'h0d || c == 8'h0a;
  endfunction

  function automatic bit is_dig(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic bit inner_is_obj();
    if (nest_depth == 0) return 0;
    return nest_is_obj[nest_depth-1];
  endfunction

  function automatic void value_end();
    gram_phase = (nest_depth == 0) ? jsv_pkg::PH_DONE : jsv_pkg::PH_AFTER;
  endfunction

  function automatic void push_nest(bit obj);
    int lim;
    lim = (lim_reg < jsv_pkg::MaxDepth) ? int'(lim_reg) : jsv_pkg::MaxDepth;
    if (nest_depth >= lim) begin
      flag_error(jsv_pkg::ErrDeep);
      return;
    end
    nest_is_obj[nest_depth] = obj;
    nest_depth++;
    gram_phase = obj ? jsv_pkg::PH_OBJ_FIRST : jsv_pkg::PH_ARR_FIRST;
  endfunction

  function automatic void pop_nest();
    if (nest_depth > 0) nest_depth--;
    value_end();
  endfunction

  function automatic void begin_value(logic [7:0] c);
    word_pos = 1;
    case (c)
      "{": begin word_pos = 0; push_nest(1); end
      "[": begin word_pos = 0; push_nest(0); end
      "\"": begin word_pos = 0; in_key = 0; gram_phase = jsv_pkg::PH_STR; end
      "t": gram_phase = jsv_pkg::PH_L_TRUE;
      "f": gram_phase = jsv_pkg::PH_L_FALSE;
      "n": gram_phase = jsv_pkg::PH_L_NULL;
      "-": begin word_pos = 0; gram_phase = jsv_pkg::PH_N_MINUS; end
      "0": begin word_pos = 0; gram_phase = jsv_pkg::PH_N_ZERO; end
      default: begin
        word_pos = 0;
        if (c >= "1" && c <= "9") gram_phase = jsv_pkg::PH_N_INT;
        else flag_error(jsv_pkg::ErrByte);
      end
    endcase
  endfunction

  function automatic void match_literal(logic [7:0] c, string w);
    if (word_pos >= w.len() || c != w[word_pos]) begin
      flag_error(jsv_pkg::ErrByte);
      return;
    end
    word_pos++;
    if (word_pos == w.len()) begin
      word_pos = 0;
      value_end();
    end
  endfunction

  function automatic void take_hex(logic [7:0] c);
    int nib;
    logic [15:0] cp;
    if (c >= "0" && c <= "9") nib = c - "0";
    else if (c >= "a" && c <= "f") nib = c - "a" + 10;
    else if (c >= "A" && c <= "F") nib = c - "A" + 10;
    else nib = -1;
    if (nib < 0) begin
      flag_error(jsv_pkg::ErrEsc);
      return;
    end
    hex_acc = {hex_acc[11:0], nib[3:0]};
    hex_cnt++;
    if (hex_cnt < 4) return;
    cp = hex_acc;
    hex_cnt = 0;
    hex_acc = '0;
    if (surr_pending) begin
      surr_pending = 0;
      if (cp < 16'hDC00 || cp > 16'hDFFF) flag_error(jsv_pkg::ErrSurr);
      else gram_phase = jsv_pkg::PH_STR;
    end else if (cp >= 16'hD800 && cp <= 16'hDBFF) begin
      surr_pending = 1;
      gram_phase = jsv_pkg::PH_SURR_BS;
    end else if (cp >= 16'hDC00 && cp <= 16'hDFFF) begin
      flag_error(jsv_pkg::ErrSurr);
    end else begin
      gram_phase = jsv_pkg::PH_STR;
    end
  endfunction

  // returns 1 when a finished number has to see the same byte again
  function automatic bit track_byte(logic [7:0] c);
    case (gram_phase)
      jsv_pkg::PH_TOP: begin
        if (!is_ws(c)) begin
          if (top_obj_reg && c != "{") flag_error(jsv_pkg::ErrTop);
          else begin_value(c);
        end
      end
      jsv_pkg::PH_VALUE: if (!is_ws(c)) begin_value(c);
      jsv_pkg::PH_ARR_FIRST: begin
        if (c == "]") pop_nest();
        else if (!is_ws(c)) begin_value(c);
      end
      jsv_pkg::PH_OBJ_FIRST, jsv_pkg::PH_OBJ_KEY: begin
        if (is_ws(c)) ;
        else if (c == "}" && gram_phase == jsv_pkg::PH_OBJ_FIRST) pop_nest();
        else if (c == "\"") begin in_key = 1; gram_phase = jsv_pkg::PH_STR; end
        else flag_error(jsv_pkg::ErrByte);
      end
      jsv_pkg::PH_COLON: begin
        if (c == ":") gram_phase = jsv_pkg::PH_VALUE;
        else if (!is_ws(c)) flag_error(jsv_pkg::ErrByte);
      end
      jsv_pkg::PH_AFTER: begin
        if (is_ws(c)) ;
        else if (c == ",")
          gram_phase = inner_is_obj() ? jsv_pkg::PH_OBJ_KEY : jsv_pkg::PH_VALUE;
        else if (c == "}" && inner_is_obj()) pop_nest();
        else if (c == "]" && !inner_is_obj()) pop_nest();
        else flag_error(jsv_pkg::ErrByte);
      end
      jsv_pkg::PH_DONE: if (!is_ws(c)) flag_error(jsv_pkg::ErrByte);
      jsv_pkg::PH_STR: begin
        if (c == "\\") gram_phase = jsv_pkg::PH_ESC;
        else if (c == "\"") begin
          if (in_key) begin in_key = 0; gram_phase = jsv_pkg::PH_COLON; end
          else value_end();
        end
      end
      jsv_pkg::PH_ESC: begin
        if (c == "u") begin hex_acc = '0; hex_cnt = 0; gram_phase = jsv_pkg::PH_HEX; end
        else if (c == "\"" || c == "\\" || c == "/" || c == "b" || c == "f" ||
                 c == "n" || c == "r" || c == "t") gram_phase = jsv_pkg::PH_STR;
        else flag_error(jsv_pkg::ErrEsc);
      end
      jsv_pkg::PH_HEX: take_hex(c);
      jsv_pkg::PH_SURR_BS: begin
        if (c == "\\") gram_phase = jsv_pkg::PH_SURR_U;
        else flag_error(jsv_pkg::ErrSurr);
      end
      jsv_pkg::PH_SURR_U: begin
        if (c == "u") begin hex_acc = '0; hex_cnt = 0; gram_phase = jsv_pkg::PH_HEX; end
        else flag_error(jsv_pkg::ErrSurr);
      end
      jsv_pkg::PH_N_MINUS: begin
        if (c == "0") gram_phase = jsv_pkg::PH_N_ZERO;
        else if (c >= "1" && c <= "9") gram_phase = jsv_pkg::PH_N_INT;
        else flag_error(jsv_pkg::ErrByte);
      end
      jsv_pkg::PH_N_ZERO, jsv_pkg::PH_N_INT: begin
        if (gram_phase == jsv_pkg::PH_N_INT && is_dig(c)) ;
        else if (c == ".") gram_phase = jsv_pkg::PH_N_DOT;
        else if (c == "e" || c == "E") gram_phase = jsv_pkg::PH_N_EXP;
        else begin value_end(); return 1; end
      end
      jsv_pkg::PH_N_DOT: begin
        if (is_dig(c)) gram_phase = jsv_pkg::PH_N_FRAC;
        else flag_error(jsv_pkg::ErrByte);
      end
      jsv_pkg::PH_N_FRAC: begin
        if (is_dig(c)) ;
        else if (c == "e" || c == "E") gram_phase = jsv_pkg::PH_N_EXP;
        else begin value_end(); return 1; end
      end
      jsv_pkg::PH_N_EXP: begin
        if (c == "+" || c == "-") gram_phase = jsv_pkg::PH_N_EXPSIGN;
        else if (is_dig(c)) gram_phase = jsv_pkg::PH_N_EXPDIG;
        else flag_error(jsv_pkg::ErrByte);
      end
      jsv_pkg::PH_N_EXPSIGN: begin
        if (is_dig(c)) gram_phase = jsv_pkg::PH_N_EXPDIG;
        else flag_error(jsv_pkg::ErrByte);
      end
      jsv_pkg::PH_N_EXPDIG: if (!is_dig(c)) begin value_end(); return 1; end
      jsv_pkg::PH_L_TRUE:  match_literal(c, "true");
      jsv_pkg::PH_L_FALSE: match_literal(c, "false");
      jsv_pkg::PH_L_NULL:  match_literal(c, "null");
      default: gram_phase = jsv_pkg::PH_ERR;
    endcase
    return 0;
  endfunction

  function automatic void predict_byte(doc_byte_t b);
    verdict_t v;
    if (track_byte(b.data)) void'(track_byte(b.data));
    if (byte_pos != 32'hFFFF_FFFF) byte_pos++;
    if (!b.last) return;
    if (err_code == jsv_pkg::ErrNone) begin
      case (gram_phase)
        jsv_pkg::PH_DONE: ;
        jsv_pkg::PH_N_ZERO, jsv_pkg::PH_N_INT, jsv_pkg::PH_N_FRAC, jsv_pkg::PH_N_EXPDIG:
          if (nest_depth != 0) flag_error(jsv_pkg::ErrTrunc);
        jsv_pkg::PH_TOP: flag_error(top_obj_reg ? jsv_pkg::ErrTop : jsv_pkg::ErrTrunc);
        default: flag_error(jsv_pkg::ErrTrunc);
      endcase
    end
    v.ok     = (err_code == jsv_pkg::ErrNone);
    v.code   = err_code;
    v.offset = (err_code == jsv_pkg::ErrNone) ? 32'd0 : err_pos;
    expected_verdicts.push_back(v);
    doc_reset();
  endfunction

  // ---------------------------------------------------------------- driver
  int burst_left = 0;
  int gap_left = 0;

  always @(posedge clk) begin
    if (rst) begin
      in_if.valid <= 1'b0;
    end else begin
      if (in_if.valid && in_if.ready) predict_byte(pending_bytes.pop_front());
      if (in_if.valid && !in_if.ready) begin
        // hold the current transaction
      end else if (gap_left > 0) begin
        gap_left--;
        in_if.valid <= 1'b0;
      end else if (pending_bytes.size() > 0) begin
        in_if.valid     <= 1'b1;
        in_if.data_byte <= pending_bytes[0].data;
        in_if.last_byte <= pending_bytes[0].last;
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 40);
          gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 7);
        end
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------- monitor
  int stall_mode = 0;

  always @(posedge clk) begin
    verdict_t want;
    cycles++;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("*** FAILED ***");
      $finish;
    end
    if (rst) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (expected_verdicts.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result: ok=%0d code=%0d off=%0d",
                     out_if.valid_res, out_if.error_code, out_if.error_offset);
        end else begin
          want = expected_verdicts.pop_front();
          if (out_if.valid_res !== want.ok || out_if.error_code !== want.code ||
              out_if.error_offset !== want.offset) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: exp ok=%0d code=%0d off=%0d, got ok=%0d code=%0d off=%0d",
                       want.ok, want.code, want.offset, out_if.valid_res,
                       out_if.error_code, out_if.error_offset);
          end
        end
      end
      if (cycles % 97 == 0) stall_mode = $urandom_range(0, 3);
      case (stall_mode)
        0: out_if.ready <= 1'b1;
        1: out_if.ready <= 1'($urandom_range(0, 1));
        2: out_if.ready <= (cycles % 4 == 0);
        default: out_if.ready <= ($urandom_range(0, 7) != 0);
      endcase
    end
  end

  // ---------------------------------------------------------------- document builder
  logic [7:0] doc_buf[$];

  function automatic void put(logic [7:0] c);
    doc_buf.push_back(c);
  endfunction

  function automatic void put_str(string s);
    for (int i = 0; i < s.len(); i++) put(s[i]);
  endfunction

  function automatic void put_ws();
    string blanks;
    blanks = " \t\r\n";
    if ($urandom_range(0, 3) == 0)
      repeat ($urandom_range(1, 2)) put(blanks[$urandom_range(0, 3)]);
  endfunction

  function automatic void put_hex4(logic [15:0] v);
    string hx;
    hx = "0123456789abcdef";
    put("\\");
    put("u");
    for (int i = 3; i >= 0; i--) put(hx[v[i*4 +: 4]]);
  endfunction

  function automatic void gen_string();
    string esc;
    esc = "\"\\/bfnrt";
    put("\"");
    repeat ($urandom_range(0, 5)) begin
      case ($urandom_range(0, 7))
        0, 1, 2: put(8'($urandom_range("a", "z")));
        3: begin put("\\"); put(esc[$urandom_range(0, 7)]); end
        4: put_hex4(16'($urandom_range(0, 16'hD7FF)));
        5: begin
          put_hex4(16'($urandom_range(16'hD800, 16'hDBFF)));
          put_hex4(16'($urandom_range(16'hDC00, 16'hDFFF)));
        end
        6: put(8'($urandom_range(0, 31)));
        default: put(8'($urandom_range(128, 255)));
      endcase
    end
    put("\"");
  endfunction

  function automatic void gen_number();
    if ($urandom_range(0, 2) == 0) put("-");
    if ($urandom_range(0, 3) == 0) put("0");
    else begin
      put(8'($urandom_range("1", "9")));
      repeat ($urandom_range(0, 3)) put(8'($urandom_range("0", "9")));
    end
    if ($urandom_range(0, 2) == 0) begin
      put(".");
      repeat ($urandom_range(1, 3)) put(8'($urandom_range("0", "9")));
    end
    if ($urandom_range(0, 3) == 0) begin
      put($urandom_range(0, 1) ? "e" : "E");
      case ($urandom_range(0, 2))
        0: put("+");
        1: put("-");
        default: ;
      endcase
      repeat ($urandom_range(1, 2)) put(8'($urandom_range("0", "9")));
    end
  endfunction

  function automatic void gen_value(int lvl, bit obj_only);
    int kind;
    int n;
    kind = obj_only ? 0 : $urandom_range(0, (lvl > 3) ? 6 : 7) % 7;
    if (kind > 1 && lvl > 3) kind = $urandom_range(2, 6);
    case (kind)
      0: begin
        put("{");
        n = $urandom_range(0, 3);
        for (int i = 0; i < n; i++) begin
          if (i > 0) put(",");
          put_ws(); gen_string(); put_ws(); put(":"); put_ws();
          gen_value(lvl + 1, 0); put_ws();
        end
        put_ws();
        put("}");
      end
      1: begin
        put("[");
        n = $urandom_range(0, 3);
        for (int i = 0; i < n; i++) begin
          if (i > 0) put(",");
          put_ws(); gen_value(lvl + 1, 0); put_ws();
        end
        put("]");
      end
      2: gen_string();
      3: gen_number();
      4: put_str("true");
      5: put_str("false");
      default: put_str("null");
    endcase
  endfunction

  function automatic void queue_doc();
    doc_byte_t b;
    for (int i = 0; i < doc_buf.size(); i++) begin
      b.data = doc_buf[i];
      b.last = (i == doc_buf.size() - 1);
      pending_bytes.push_back(b);
    end
    doc_buf.delete();
  endfunction

  function automatic void queue_text(string s);
    put_str(s);
    queue_doc();
  endfunction

  function automatic void queue_nest(int n, bit close_all);
    repeat (n) put("[");
    if (close_all) repeat (n) put("]");
    queue_doc();
  endfunction

  function automatic int random_doc(bit top_obj);
    int pos;
    int n;
    put_ws();
    gen_value(0, top_obj && $urandom_range(0, 9) != 0);
    put_ws();
    // break a share of the documents
    if ($urandom_range(0, 9) < 3) begin
      pos = $urandom_range(0, doc_buf.size() - 1);
      case ($urandom_range(0, 3))
        0: doc_buf[pos] = 8'($urandom_range(0, 255));
        1: while (doc_buf.size() > pos + 1) void'(doc_buf.pop_back());
        2: doc_buf.insert(pos, 8'($urandom_range(0, 255)));
        default: put(8'($urandom_range(0, 255)));
      endcase
    end
    n = doc_buf.size();
    queue_doc();
    return n;
  endfunction

  // ---------------------------------------------------------------- config port
  task automatic reg_write(logic [1:0] idx, logic [31:0] val);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx[0], 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == jsv_pkg::RegDepthLimit) lim_reg = val[10:0];
    else top_obj_reg = val[0];
  endtask

  task automatic drain();
    while (pending_bytes.size() > 0 || expected_verdicts.size() > 0 || in_if.valid)
      @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic random_phase(int budget);
    int sent;
    sent = 0;
    while (sent < budget) sent += random_doc(top_obj_reg);
    drain();
  endtask

  initial begin
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    in_if.valid = 1'b0; in_if.data_byte = '0; in_if.last_byte = 1'b0;
    out_if.ready = 1'b0;
    lim_reg = 11'd1024;
    top_obj_reg = 1'b1;
    doc_reset();
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // defaults: object required at top
    queue_text("{}");
    queue_text(" {\"k\" : [1, -0.5e+3, 2E-1, true, false, null, \"\\u00e9\"]} \n");
    queue_text("[1]");
    queue_text("  ");
    queue_text("{\"a\":1} x");
    queue_text("{\"a\" 1}");
    queue_text("{,}");
    queue_text("{\"s\":\"\\ud83d\\ude00\"}");
    queue_text("{\"s\":\"\\udc00\"}");
    queue_text("{\"s\":\"\\ud800x\"}");
    queue_text("{\"s\":\"\\ud800\\u0041\"}");
    queue_text("{\"s\":\"\\x\"}");
    queue_text("{\"s\":\"\\u12g4\"}");
    queue_text("{\"s\":\"\t\x01\xff\"}");
    queue_text("{\"a\":tru}");
    queue_text("{\"a\":01}");
    queue_text("{\"a\":[1.]}");
    queue_text("{\"a\":");
    drain();

    reg_write(jsv_pkg::RegTopObject, 32'd0);
    reg_write(jsv_pkg::RegDepthLimit, 32'd3);
    queue_text("5");
    queue_text("-");
    queue_text("1e");
    queue_text("[5");
    queue_text("[1,]");
    queue_text("nul");
    queue_text("  ");
    queue_text("[[[1]]]");
    queue_text("[[[[1]]]]");
    queue_text("\"\xff\x7f\"");
    drain();
    random_phase(100);

    // a limit above the stack size is clamped to it
    reg_write(jsv_pkg::RegDepthLimit, 32'h7FF);
    queue_nest(1025, 0);
    drain();

    reg_write(jsv_pkg::RegDepthLimit, 32'd0);
    queue_text("[]");
    queue_text("7");
    drain();
    random_phase(30);

    reg_write(jsv_pkg::RegDepthLimit, 32'd1);
    random_phase(40);

    reg_write(jsv_pkg::RegTopObject, 32'd1);
    reg_write(jsv_pkg::RegDepthLimit, 32'd5);
    random_phase(80);

    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("mismatches: %0d", mismatches);
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
